>>> sv/cfar_pkg.sv
// Shared types, constants and state encoding of the CFAR threshold detector.
`default_nettype none
package cfar_pkg;

  localparam int unsigned MAX_ROWS  = 64;
  localparam int unsigned MAX_COLS  = 64;
  localparam int unsigned MAX_BEAMS = 16;

  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned BEAM_W      = $clog2(MAX_BEAMS);
  localparam int unsigned PWR_W       = 32;
  localparam int unsigned NOISE_W     = 41;
  localparam int unsigned MUL_A_W     = 32;
  localparam int unsigned MUL_B_W     = 21;
  localparam int unsigned MUL_P_W     = MUL_A_W + MUL_B_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BEAMS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COL = 3'd4;

  localparam logic [6:0]  ROWS_RESET      = 7'd64;
  localparam logic [6:0]  COLS_RESET      = 7'd64;
  localparam logic [4:0]  BEAMS_RESET     = 5'd16;
  localparam logic [23:0] SCALE_RESET     = 24'd2560;
  localparam logic [5:0]  FIRST_COL_RESET = 6'd30;

  localparam logic [7:0] GUARD_LO = 8'd10;
  localparam logic [6:0] GUARD_HI = 7'd11;

  typedef struct packed {
    logic              valid;
    logic [BEAM_W-1:0] beam;
    logic [PWR_W-1:0]  power;
  } best_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    best_entry_t      data;
  } best_wr_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [PWR_W-1:0] data;
  } pwr_wr_t;

  typedef struct packed {
    logic               we;
    logic [BEAM_W-1:0]  addr;
    logic [NOISE_W-1:0] data;
  } noise_wr_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SQ_I,
    ST_SQ_Q,
    ST_SMP_WR,
    ST_THR_A,
    ST_THR_B,
    ST_THR_C,
    ST_EV_RD,
    ST_EV_WT,
    ST_EV_DET,
    ST_EV_N,
    ST_EV_P1,
    ST_EV_P2,
    ST_EV_Q1,
    ST_EV_Q2,
    ST_RD_SCAN,
    ST_RD_CHK,
    ST_RD_NS,
    ST_RD_CLOSE
  } state_t;

endpackage
`default_nettype wire

>>> sv/cfar_mul.sv
// Shared unsigned multiplier with a registered product.
`default_nettype none
module cfar_mul
  import cfar_pkg::*;
(
  input  wire                 clk,
  input  wire [MUL_A_W-1:0]   a,
  input  wire [MUL_B_W-1:0]   b,
  output logic [MUL_P_W-1:0]  p_r
);

  logic [MUL_P_W-1:0] p_nxt;

  assign p_nxt = MUL_P_W'(a) * MUL_P_W'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule
`default_nettype wire

>>> sv/cfar_pwr_store.sv
// Cell power store of the beam being streamed, one write and one registered read port.
`default_nettype none
module cfar_pwr_store
  import cfar_pkg::*;
(
  input  wire                clk,
  input  pwr_wr_t            wr,
  input  wire                re,
  input  wire [IDX_W-1:0]    raddr,
  output logic [PWR_W-1:0]   rdata_r
);

  logic [PWR_W-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/cfar_best_table.sv
// Per-cell strongest-beam table, one write and one registered read port.
`default_nettype none
module cfar_best_table
  import cfar_pkg::*;
(
  input  wire              clk,
  input  best_wr_t         wr,
  input  wire              re,
  input  wire [IDX_W-1:0]  raddr,
  output best_entry_t      rdata_r
);

  best_entry_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/cfar_noise_ram.sv
// Noise sum of each beam, one write and one registered read port.
`default_nettype none
module cfar_noise_ram
  import cfar_pkg::*;
(
  input  wire                 clk,
  input  noise_wr_t           wr,
  input  wire                 re,
  input  wire [BEAM_W-1:0]    raddr,
  output logic [NOISE_W-1:0]  rdata_r
);

  logic [NOISE_W-1:0] mem [MAX_BEAMS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/cfar_threshold_detector_unit.sv
// Top level of the multi-beam cell-averaging CFAR detector with strongest-beam table.
// Usage: items enter on the in_ channel (valid/stall). With in_cmd low an item is one
// range-Doppler cell of I/Q samples, streamed row-major, beam after beam. Its power is
// stored and, for the noise rows, added to the beam's noise sum, with in_stall high
// until that is done. The last cell of a beam with a nonzero noise sum starts
// a sweep over the stored cells: ST_THR_A to ST_THR_C form the threshold, each cell
// takes ST_EV_RD, a tested one also ST_EV_WT and ST_EV_DET, and a detection compared
// with an earlier beam also ST_EV_N to ST_EV_Q2, all paced by the one shared
// multiplier and the single read port of each memory. Samples after the last beam of
// a frame are dropped. With in_cmd high an item requests the next detection:
// the table is scanned entry by entry, and one result leaves on the out_ channel.
// When no entry is left, a result with out_found low is given, the frame restarts and
// the table is cleared in ST_CLEAR, during which no item is accepted. After reset the
// same clearing pass runs before the first item is taken. The result sits in an
// output register; while out_stall is high it holds, samples are still accepted, and
// a readout waits for the register to be free.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block is idle.
`default_nettype none
module cfar_threshold_detector_unit
  import cfar_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  wire                     in_cmd,
  input  wire signed [15:0]       in_sample_i,
  input  wire signed [15:0]       in_sample_q,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic                    out_found,
  output logic [11:0]             out_cell_index,
  output logic [3:0]              out_beam_number,
  output logic [31:0]             out_cell_power,
  output logic [40:0]             out_beam_noise_sum,
  input  wire                     cfg_we,
  input  wire [CFG_IDX_W-1:0]     cfg_index,
  input  wire [CFG_DATA_W-1:0]    cfg_data
);

  state_t state_r, state_nxt;

  logic [6:0]  rows_r, cols_r;
  logic [4:0]  beams_r;
  logic [23:0] scale_r;
  logic [5:0]  fcol_r;

  logic [6:0]  rows_c, cols_c;
  logic [4:0]  beams_c;
  logic [12:0] beam_cells;
  logic [3:0]  nz_rows;
  logic [9:0]  count;
  logic [5:0]  half;

  logic [15:0] abs_i_r, abs_i_nxt, abs_q_r, abs_q_nxt;
  logic [IDX_W-1:0]  cc_r, cc_nxt;
  logic [BEAM_W-1:0] beam_r, beam_nxt;
  logic [NOISE_W-1:0] acc_r, acc_nxt;
  logic [IDX_W:0] rp_r, rp_nxt;
  logic full_r, full_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;

  logic [BEAM_W-1:0]  ev_beam_r, ev_beam_nxt;
  logic [NOISE_W-1:0] ev_noise_r, ev_noise_nxt;
  logic [64:0] thr_r, thr_nxt;
  logic [MUL_P_W-1:0] lo_r, lo_nxt;
  logic [72:0] p_r, p_nxt;
  logic [72:0] q_val;
  logic [6:0]  ev_row_r, ev_row_nxt, ev_col_r, ev_col_nxt;
  logic [IDX_W:0] ev_idx_r, ev_idx_nxt;
  logic tested, det;

  logic        out_valid_r, out_valid_nxt;
  logic        out_found_r, out_found_nxt;
  logic [11:0] out_idx_r, out_idx_nxt;
  logic [3:0]  out_beam_r, out_beam_nxt;
  logic [31:0] out_pwr_r, out_pwr_nxt;
  logic [40:0] out_noise_r, out_noise_nxt;
  logic        out_free;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  pwr_wr_t     pws_wr;
  logic        pws_re;
  logic [IDX_W-1:0] pws_raddr;
  logic [PWR_W-1:0] pws_rdata;
  best_wr_t    tbl_wr;
  logic        tbl_re;
  logic [IDX_W-1:0] tbl_raddr;
  best_entry_t tbl_rdata;
  noise_wr_t   nz_wr;
  logic        nz_re;
  logic [BEAM_W-1:0] nz_raddr;
  logic [NOISE_W-1:0] nz_rdata;

  logic [PWR_W-1:0]   smp_pw;
  logic               smp_store, smp_add, smp_last;
  logic [NOISE_W-1:0] smp_acc;

  cfar_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  cfar_pwr_store u_pwr_store (
    .clk(clk), .wr(pws_wr), .re(pws_re), .raddr(pws_raddr), .rdata_r(pws_rdata)
  );

  cfar_best_table u_best_table (
    .clk(clk), .wr(tbl_wr), .re(tbl_re), .raddr(tbl_raddr), .rdata_r(tbl_rdata)
  );

  cfar_noise_ram u_noise_ram (
    .clk(clk), .wr(nz_wr), .re(nz_re), .raddr(nz_raddr), .rdata_r(nz_rdata)
  );

  // Geometry clamped to the supported ranges.
  always_comb begin
    rows_c  = (rows_r == 7'd0) ? 7'd1 : ((rows_r > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : rows_r);
    cols_c  = (cols_r == 7'd0) ? 7'd1 : ((cols_r > 7'(MAX_COLS)) ? 7'(MAX_COLS) : cols_r);
    beams_c = (beams_r == 5'd0) ? 5'd1 :
              ((beams_r > 5'(MAX_BEAMS)) ? 5'(MAX_BEAMS) : beams_r);
    beam_cells = 13'(rows_c) * 13'(cols_c);
    nz_rows    = 4'((rows_c - 7'd1) >> 2);
    count      = 10'(nz_rows) * 10'(cols_c);
    half       = rows_c[6:1];
  end

  always_comb begin
    tested = (ev_col_r >= {1'b0, fcol_r}) &&
             !((({1'b0, ev_row_r} + GUARD_LO) >= {2'b0, half}) &&
               (ev_row_r < ({1'b0, half} + GUARD_HI)));
    det    = {4'b0, mul_p, 8'b0} > thr_r;
    q_val  = {mul_p[51:0], 21'b0} + 73'(lo_r);
    smp_pw    = lo_r[31:0] + mul_p[31:0];
    smp_store = {1'b0, cc_r} < beam_cells;
    smp_add   = smp_store && ({1'b0, cc_r} < {3'b0, count});
    smp_acc   = acc_r + (smp_add ? NOISE_W'(smp_pw) : '0);
    smp_last  = ({1'b0, cc_r} + 13'd1) >= beam_cells;
    out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    state_nxt     = state_r;
    abs_i_nxt     = abs_i_r;
    abs_q_nxt     = abs_q_r;
    cc_nxt        = cc_r;
    beam_nxt      = beam_r;
    acc_nxt       = acc_r;
    rp_nxt        = rp_r;
    full_nxt      = full_r;
    clr_nxt       = clr_r;
    ev_beam_nxt   = ev_beam_r;
    ev_noise_nxt  = ev_noise_r;
    thr_nxt       = thr_r;
    lo_nxt        = lo_r;
    p_nxt         = p_r;
    ev_row_nxt    = ev_row_r;
    ev_col_nxt    = ev_col_r;
    ev_idx_nxt    = ev_idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    out_beam_nxt  = out_beam_r;
    out_pwr_nxt   = out_pwr_r;
    out_noise_nxt = out_noise_r;
    mul_a         = '0;
    mul_b         = '0;
    pws_wr        = '0;
    pws_re        = 1'b0;
    pws_raddr     = ev_idx_r[IDX_W-1:0];
    tbl_wr        = '0;
    tbl_re        = 1'b0;
    tbl_raddr     = ev_idx_r[IDX_W-1:0];
    nz_wr         = '0;
    nz_re         = 1'b0;
    nz_raddr      = tbl_rdata.beam;
    in_stall      = (state_r != ST_IDLE);

    case (state_r)
      ST_CLEAR: begin
        tbl_wr.we   = 1'b1;
        tbl_wr.addr = clr_r;
        if (clr_r == IDX_W'(STORE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_cmd) begin
            state_nxt = ST_RD_SCAN;
          end else if (!full_r) begin
            abs_i_nxt = in_sample_i[15] ? 16'(-in_sample_i) : in_sample_i;
            abs_q_nxt = in_sample_q[15] ? 16'(-in_sample_q) : in_sample_q;
            state_nxt = ST_SQ_I;
          end
        end
      end
      ST_SQ_I: begin
        mul_a     = MUL_A_W'(abs_i_r);
        mul_b     = MUL_B_W'(abs_i_r);
        state_nxt = ST_SQ_Q;
      end
      ST_SQ_Q: begin
        lo_nxt    = mul_p;
        mul_a     = MUL_A_W'(abs_q_r);
        mul_b     = MUL_B_W'(abs_q_r);
        state_nxt = ST_SMP_WR;
      end
      ST_SMP_WR: begin
        pws_wr.we   = smp_store;
        pws_wr.addr = cc_r;
        pws_wr.data = smp_pw;
        state_nxt   = ST_IDLE;
        if (smp_last) begin
          nz_wr.we     = 1'b1;
          nz_wr.addr   = beam_r;
          nz_wr.data   = smp_acc;
          ev_beam_nxt  = beam_r;
          ev_noise_nxt = smp_acc;
          acc_nxt      = '0;
          cc_nxt       = '0;
          ev_row_nxt   = '0;
          ev_col_nxt   = '0;
          ev_idx_nxt   = '0;
          if (({1'b0, beam_r} + 5'd1) >= beams_c) begin
            full_nxt = 1'b1;
          end else begin
            beam_nxt = beam_r + 1'b1;
          end
          if (smp_acc != '0) begin
            state_nxt = ST_THR_A;
          end
        end else begin
          acc_nxt = smp_acc;
          cc_nxt  = cc_r + 1'b1;
        end
      end
      ST_THR_A: begin
        mul_a     = MUL_A_W'(scale_r);
        mul_b     = ev_noise_r[20:0];
        state_nxt = ST_THR_B;
      end
      ST_THR_B: begin
        lo_nxt    = mul_p;
        mul_a     = MUL_A_W'(scale_r);
        mul_b     = {1'b0, ev_noise_r[40:21]};
        state_nxt = ST_THR_C;
      end
      ST_THR_C: begin
        thr_nxt   = {mul_p[43:0], 21'b0} + 65'(lo_r);
        state_nxt = ST_EV_RD;
      end
      ST_EV_RD: begin
        if (ev_idx_r >= beam_cells) begin
          state_nxt = ST_IDLE;
        end else if (tested) begin
          pws_re    = 1'b1;
          tbl_re    = 1'b1;
          state_nxt = ST_EV_WT;
        end else begin
          state_nxt = ST_EV_RD;
        end
      end
      ST_EV_WT: begin
        mul_a     = pws_rdata;
        mul_b     = MUL_B_W'(count);
        state_nxt = ST_EV_DET;
      end
      ST_EV_DET: begin
        state_nxt = ST_EV_RD;
        if (det) begin
          if (!tbl_rdata.valid) begin
            tbl_wr.we         = 1'b1;
            tbl_wr.data.valid = 1'b1;
            tbl_wr.data.beam  = ev_beam_r;
            tbl_wr.data.power = pws_rdata;
          end else begin
            nz_re     = 1'b1;
            state_nxt = ST_EV_N;
          end
        end
      end
      ST_EV_N: begin
        mul_a     = pws_rdata;
        mul_b     = nz_rdata[20:0];
        state_nxt = ST_EV_P1;
      end
      ST_EV_P1: begin
        lo_nxt    = mul_p;
        mul_a     = pws_rdata;
        mul_b     = {1'b0, nz_rdata[40:21]};
        state_nxt = ST_EV_P2;
      end
      ST_EV_P2: begin
        p_nxt     = q_val;
        mul_a     = tbl_rdata.power;
        mul_b     = ev_noise_r[20:0];
        state_nxt = ST_EV_Q1;
      end
      ST_EV_Q1: begin
        lo_nxt    = mul_p;
        mul_a     = tbl_rdata.power;
        mul_b     = {1'b0, ev_noise_r[40:21]};
        state_nxt = ST_EV_Q2;
      end
      ST_EV_Q2: begin
        state_nxt = ST_EV_RD;
        if (p_r > q_val) begin
          tbl_wr.we         = 1'b1;
          tbl_wr.data.valid = 1'b1;
          tbl_wr.data.beam  = ev_beam_r;
          tbl_wr.data.power = pws_rdata;
        end
      end
      ST_RD_SCAN: begin
        tbl_raddr = rp_r[IDX_W-1:0];
        if (rp_r[IDX_W]) begin
          state_nxt = ST_RD_CLOSE;
        end else begin
          tbl_re    = 1'b1;
          state_nxt = ST_RD_CHK;
        end
      end
      ST_RD_CHK: begin
        if (tbl_rdata.valid) begin
          nz_re     = 1'b1;
          state_nxt = ST_RD_NS;
        end else begin
          rp_nxt    = rp_r + 1'b1;
          state_nxt = ST_RD_SCAN;
        end
      end
      ST_RD_NS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_idx_nxt   = rp_r[IDX_W-1:0];
          out_beam_nxt  = tbl_rdata.beam;
          out_pwr_nxt   = tbl_rdata.power;
          out_noise_nxt = nz_rdata;
          rp_nxt        = rp_r + 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RD_CLOSE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_idx_nxt   = '0;
          out_beam_nxt  = '0;
          out_pwr_nxt   = '0;
          out_noise_nxt = '0;
          cc_nxt        = '0;
          beam_nxt      = '0;
          acc_nxt       = '0;
          rp_nxt        = '0;
          full_nxt      = 1'b0;
          clr_nxt       = '0;
          state_nxt     = ST_CLEAR;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Cells that are skipped, rejected or finished step the sweep on.
    if ((state_r == ST_EV_RD && ev_idx_r < beam_cells && !tested) ||
        (state_r == ST_EV_DET && (!det || !tbl_rdata.valid)) ||
        (state_r == ST_EV_Q2)) begin
      ev_idx_nxt = ev_idx_r + 1'b1;
      if (ev_col_r + 7'd1 == cols_c) begin
        ev_col_nxt = '0;
        ev_row_nxt = ev_row_r + 1'b1;
      end else begin
        ev_col_nxt = ev_col_r + 1'b1;
      end
    end
    if (state_r == ST_EV_DET || state_r == ST_EV_Q2) begin
      tbl_wr.addr = ev_idx_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      rows_r      <= ROWS_RESET;
      cols_r      <= COLS_RESET;
      beams_r     <= BEAMS_RESET;
      scale_r     <= SCALE_RESET;
      fcol_r      <= FIRST_COL_RESET;
      cc_r        <= '0;
      beam_r      <= '0;
      acc_r       <= '0;
      rp_r        <= '0;
      full_r      <= 1'b0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cc_r        <= cc_nxt;
      beam_r      <= beam_nxt;
      acc_r       <= acc_nxt;
      rp_r        <= rp_nxt;
      full_r      <= full_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS:      rows_r  <= cfg_data[6:0];
          REG_COLS:      cols_r  <= cfg_data[6:0];
          REG_BEAMS:     beams_r <= cfg_data[4:0];
          REG_SCALE:     scale_r <= cfg_data[23:0];
          REG_FIRST_COL: fcol_r  <= cfg_data[5:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    abs_i_r     <= abs_i_nxt;
    abs_q_r     <= abs_q_nxt;
    ev_beam_r   <= ev_beam_nxt;
    ev_noise_r  <= ev_noise_nxt;
    thr_r       <= thr_nxt;
    lo_r        <= lo_nxt;
    p_r         <= p_nxt;
    ev_row_r    <= ev_row_nxt;
    ev_col_r    <= ev_col_nxt;
    ev_idx_r    <= ev_idx_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_beam_r  <= out_beam_nxt;
    out_pwr_r   <= out_pwr_nxt;
    out_noise_r <= out_noise_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_found          = out_found_r;
  assign out_cell_index     = out_idx_r;
  assign out_beam_number    = out_beam_r;
  assign out_cell_power     = out_pwr_r;
  assign out_beam_noise_sum = out_noise_r;

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the multi-beam CFAR detector: directed table, random frames.
`default_nettype none
module tb_top;
  import cfar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bit        found;
    bit [11:0] cix;
    bit [3:0]  beam;
    bit [31:0] pwr;
    bit [40:0] noise;
  } det_t;

  typedef struct {
    bit      cmd;
    shortint si;
    shortint sq;
    bit      typed;
    det_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = 1'b0;
  logic signed [15:0] in_sample_i = '0;
  logic signed [15:0] in_sample_q = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_found;
  logic [11:0] out_cell_index;
  logic [3:0] out_beam_number;
  logic [31:0] out_cell_power;
  logic [40:0] out_beam_noise_sum;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cfar_threshold_detector_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Detector state as this testbench predicts it
  bit [6:0] rows_r = ROWS_RESET;
  bit [6:0] cols_r = COLS_RESET;
  bit [4:0] beams_r = BEAMS_RESET;
  bit [23:0] scale_r = SCALE_RESET;
  bit [5:0] fcol_r = FIRST_COL_RESET;
  bit [31:0] pwr_store [STORE_DEPTH];
  bit tbl_valid [STORE_DEPTH];
  bit [3:0] tbl_beam [STORE_DEPTH];
  bit [31:0] tbl_pwr [STORE_DEPTH];
  bit [40:0] beam_noise [MAX_BEAMS];
  int unsigned cell_cnt, beam_cnt, rd_ptr;
  bit [63:0] noise_acc;
  bit frame_done;

  det_t pending_dets [$];
  int errors = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void sweep_beam(int unsigned rows, int unsigned cols, int unsigned b,
                                     bit [63:0] noise);
    bit [127:0] thr, lhs, p, q;
    int unsigned cnt, ix;
    int g_lo, g_hi;
    cnt = ((rows - 1) / 4) * cols;
    g_lo = int'(rows / 2) - 10;
    g_hi = int'(rows / 2) + 11;
    if (noise == 0) return;
    thr = 128'(noise) * 128'(scale_r);
    for (int r = 0; r < rows; r++) begin
      if (r >= g_lo && r < g_hi) continue;
      for (int c = fcol_r; c < cols; c++) begin
        ix = r * cols + c;
        if (ix >= STORE_DEPTH) continue;
        lhs = 128'(pwr_store[ix]) * 128'(cnt) * 128'd256;
        if (!(lhs > thr)) continue;
        if (tbl_valid[ix]) begin
          p = 128'(pwr_store[ix]) * 128'(beam_noise[tbl_beam[ix]]);
          q = 128'(tbl_pwr[ix]) * 128'(noise);
          if (!(p > q)) continue;
        end
        tbl_valid[ix] = 1'b1;
        tbl_beam[ix] = b[3:0];
        tbl_pwr[ix] = pwr_store[ix];
      end
    end
  endfunction

  function automatic bit predict_item(bit cmd, logic signed [15:0] si, logic signed [15:0] sq,
                                      output det_t res);
    int unsigned rows, cols, beams, cell_total, nrows;
    longint a, b2;
    bit [31:0] pw;
    res = '0;
    rows = clamp_to(rows_r, MAX_ROWS);
    cols = clamp_to(cols_r, MAX_COLS);
    beams = clamp_to(beams_r, MAX_BEAMS);
    if (!cmd) begin
      cell_total = rows * cols;
      nrows = (rows - 1) / 4;
      a = si;
      b2 = sq;
      pw = 32'(a * a + b2 * b2);
      if (frame_done) return 1'b0;
      if (cell_cnt < cell_total && cell_cnt < STORE_DEPTH) begin
        pwr_store[cell_cnt] = pw;
        if (cell_cnt / cols < nrows) noise_acc += pw;
      end
      if (cell_cnt + 1 >= cell_total) begin
        beam_noise[beam_cnt % MAX_BEAMS] = noise_acc[40:0];
        sweep_beam(rows, cols, beam_cnt % MAX_BEAMS, noise_acc);
        noise_acc = 0;
        cell_cnt = 0;
        if (beam_cnt + 1 >= beams) frame_done = 1'b1;
        else beam_cnt++;
      end else begin
        cell_cnt++;
      end
      return 1'b0;
    end
    while (rd_ptr < STORE_DEPTH && !tbl_valid[rd_ptr]) rd_ptr++;
    if (rd_ptr < STORE_DEPTH) begin
      res.found = 1'b1;
      res.cix = rd_ptr[11:0];
      res.beam = tbl_beam[rd_ptr];
      res.pwr = tbl_pwr[rd_ptr];
      res.noise = beam_noise[tbl_beam[rd_ptr]];
      rd_ptr++;
      return 1'b1;
    end
    foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
    cell_cnt = 0;
    beam_cnt = 0;
    rd_ptr = 0;
    noise_acc = 0;
    frame_done = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_item(input bit cmd, input logic signed [15:0] si,
                           input logic signed [15:0] sq, output det_t res, output bit got);
    bit ok;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_sample_i <= si;
    in_sample_q <= sq;
    do begin
      @(negedge clk);
      ok = !in_stall;
      @(posedge clk);
    end while (!ok);
    items_sent++;
    got = predict_item(cmd, si, sq, res);
  endtask

  task automatic send_checked(input bit cmd, input logic signed [15:0] si,
                              input logic signed [15:0] sq, output bit found);
    det_t res;
    bit got;
    send_item(cmd, si, sq, res, got);
    if (got) pending_dets = {pending_dets, res};
    found = res.found;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] ix, input int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= ix;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (ix)
      REG_ROWS: rows_r = val[6:0];
      REG_COLS: cols_r = val[6:0];
      REG_BEAMS: beams_r = val[4:0];
      REG_SCALE: scale_r = val[23:0];
      REG_FIRST_COL: fcol_r = val[5:0];
      default: ;
    endcase
  endtask

  task automatic settle_and_configure(input int unsigned rows, input int unsigned cols,
                                      input int unsigned beams, input int unsigned scale,
                                      input int unsigned fcol);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_dets.size() != 0) @(posedge clk);
    repeat (4400) @(posedge clk);
    write_reg(REG_ROWS, rows);
    write_reg(REG_COLS, cols);
    write_reg(REG_BEAMS, beams);
    write_reg(REG_SCALE, scale);
    write_reg(REG_FIRST_COL, fcol);
  endtask

  task automatic stream_frame();
    int unsigned rows, cols, beams;
    bit found, quiet;
    logic signed [15:0] si, sq;
    rows = clamp_to(rows_r, MAX_ROWS);
    cols = clamp_to(cols_r, MAX_COLS);
    beams = clamp_to(beams_r, MAX_BEAMS);
    for (int b = 0; b < beams; b++) begin
      quiet = ($urandom_range(19) == 0);
      for (int k = 0; k < rows * cols; k++) begin
        send_idle_pct = (items_sent / 60 % 4 == 1) ? 65 : (items_sent / 60 % 4 == 3) ? 8 : 0;
        recv_stall_pct = (items_sent / 60 % 4 == 2) ? 65 : (items_sent / 60 % 4 == 3) ? 8 : 0;
        if (k / cols < (rows - 1) / 4) begin
          si = quiet ? 16'sd0 : 16'($urandom_range(80)) - 16'sd40;
          sq = quiet ? 16'sd0 : 16'($urandom_range(80)) - 16'sd40;
        end else if ($urandom_range(3) == 0) begin
          si = 16'($urandom);
          sq = 16'($urandom);
        end else begin
          si = 16'($urandom_range(120)) - 16'sd60;
          sq = 16'($urandom_range(120)) - 16'sd60;
        end
        send_checked(1'b0, si, sq, found);
        if ($urandom_range(299) == 0) send_checked(1'b1, 16'($urandom), 16'($urandom), found);
      end
    end
    repeat ($urandom_range(2)) send_checked(1'b0, 16'($urandom), 16'($urandom), found);
    do send_checked(1'b1, 16'($urandom), 16'($urandom), found); while (found);
  endtask

  stim_row_t directed [] = '{
    '{1'b1, 16'sd0, 16'sd0, 1'b1, det_t'('0)},
    '{1'b0, 16'sd0, 16'sd0, 1'b0, det_t'('0)},
    '{1'b0, 16'sd0, 16'sd0, 1'b0, det_t'('0)},
    '{1'b0, -16'sd32768, -16'sd32768, 1'b0, det_t'('0)},
    '{1'b0, 16'sd32767, 16'sd32767, 1'b0, det_t'('0)},
    '{1'b0, -16'sd32768, 16'sd32767, 1'b0, det_t'('0)},
    '{1'b0, 16'sd1, -16'sd1, 1'b0, det_t'('0)},
    '{1'b0, -16'sd1, 16'sd0, 1'b0, det_t'('0)},
    '{1'b0, 16'sd21845, -16'sd21846, 1'b0, det_t'('0)},
    '{1'b0, 16'sd0, 16'sd32767, 1'b0, det_t'('0)},
    '{1'b0, 16'sd5, 16'sd7, 1'b0, det_t'('0)},
    '{1'b0, 16'sd1000, 16'sd1000, 1'b0, det_t'('0)},
    '{1'b0, -16'sd1000, 16'sd1000, 1'b0, det_t'('0)},
    '{1'b1, 16'sd0, 16'sd0, 1'b1, det_t'('0)},
    '{1'b1, -16'sd1, -16'sd1, 1'b1, det_t'('0)}
  };

  initial begin
    det_t res;
    bit got;
    foreach (tbl_valid[k]) tbl_valid[k] = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    settle_and_configure(5, 2, 1, 0, 0);
    foreach (directed[n]) begin
      send_item(directed[n].cmd, directed[n].si, directed[n].sq, res, got);
      if (got) pending_dets = {pending_dets, (directed[n].typed ? directed[n].want : res)};
    end
    settle_and_configure(64, 1, 4, 0, 0);
    stream_frame();
    settle_and_configure(5, 127, 1, 24'hFFFFFF, 63);
    stream_frame();
    settle_and_configure(0, 0, 0, 256, 0);
    stream_frame();
    settle_and_configure(22, 1, 16, 1024, 0);
    stream_frame();
    while (items_sent < 850) begin
      settle_and_configure($urandom_range(40, 22), $urandom_range(6, 1), $urandom_range(4, 1),
                           ($urandom_range(5) == 0) ? 0 : $urandom_range(25600, 256),
                           $urandom_range(2));
      stream_frame();
    end
    in_valid <= 1'b0;
    while (pending_dets.size() != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(negedge clk) begin
    det_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_found, out_cell_index, out_beam_number, out_cell_power, out_beam_noise_sum};
      if (pending_dets.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result: %p", got);
      end else begin
        want = pending_dets.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
